/* src/fms_pkg.sv */
package fms_pkg;

  localparam int unsigned POS_BITS = 16;
  localparam int unsigned TICK_BITS = 32;
  localparam int unsigned TEMP_BITS = 16;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned CFG_INDEX_BITS = 3;

  localparam int unsigned TICKS_PER_SECOND = 1000;

  typedef logic [POS_BITS-1:0] pos_t;

  localparam pos_t MAX_POSITION_RESET = 16'hFFFF;
  localparam logic [TICK_BITS-1:0] SLOW_TICKS_RESET = TICK_BITS'(TICKS_PER_SECOND * 3);
  localparam pos_t HOME_BEYOND_STEPS = 16'd1000;
  localparam pos_t HOME_RELOAD_VALUE = 16'd1200;

  // Division by ten of a magnitude below 2^32: multiply by ceil(2^35 / 10), keep bits 63:35.
  localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  typedef enum logic [2:0] {
    KIND_POLL      = 3'd0,
    KIND_HALT      = 3'd1,
    KIND_ABS_MOVE  = 3'd2,
    KIND_HOME      = 3'd3,
    KIND_REL_IN    = 3'd4,
    KIND_REL_OUT   = 3'd5,
    KIND_REL_END   = 3'd6,
    KIND_ABORT_HOME = 3'd7
  } kind_e;

  typedef enum logic [3:0] {
    MODE_IDLE       = 4'd0,
    MODE_START_HOME = 4'd1,
    MODE_OFF_SW     = 4'd2,
    MODE_BEYOND_SW  = 4'd3,
    MODE_TO_SW      = 4'd4,
    MODE_PRE_BLC    = 4'd5,
    MODE_POST_BLC   = 4'd6,
    MODE_IN_SLOW    = 4'd7,
    MODE_IN_FAST    = 4'd8,
    MODE_OUT_SLOW   = 4'd9,
    MODE_OUT_FAST   = 4'd10
  } mode_e;

  typedef enum logic [2:0] {
    REQ_NONE = 3'd0,
    REQ_HOME = 3'd1,
    REQ_ABS  = 3'd2,
    REQ_HALT = 3'd3,
    REQ_IN   = 3'd4,
    REQ_OUT  = 3'd5
  } req_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MAX_POSITION    = 3'd0,
    CFG_BACKLASH_ENABLE = 3'd1,
    CFG_BACKLASH_STEPS  = 3'd2,
    CFG_SLOW_TICKS      = 3'd3,
    CFG_COMP_ENABLE     = 3'd4,
    CFG_TEMP_COEFF      = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]                 kind;
    pos_t                       current_position;
    logic                       home_switch_pressed;
    logic [TICK_BITS-1:0]       now_ticks;
    pos_t                       new_target;
    logic signed [TEMP_BITS-1:0] current_temp;
    logic                       probe_attached;
    pos_t                       last_saved_position;
    logic signed [TEMP_BITS-1:0] comp_start_temp;
    pos_t                       comp_start_position;
  } fms_in_t;

  typedef struct packed {
    pos_t target_position;
    logic load_position;
    pos_t load_value;
    logic current_high;
    logic speed_high;
    logic moving_flag;
    logic homing_flag;
    logic homed_flag;
    logic save_position;
    logic temp_comp_off;
    logic temp_comp_restart;
  } fms_out_t;

  typedef struct packed {
    pos_t                        max_position;
    logic                        backlash_enable;
    logic [15:0]                 backlash_steps;
    logic [TICK_BITS-1:0]        slow_phase_ticks;
    logic                        comp_at_start_enable;
    logic signed [TEMP_BITS-1:0] temp_coefficient;
  } fms_cfg_t;

endpackage

/* src/fms_core.sv */
module fms_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  fms_pkg::fms_in_t   item,
  input  logic signed [31:0] comp_product,
  input  fms_pkg::fms_cfg_t  cfg,
  output fms_pkg::fms_out_t  res
);
  import fms_pkg::*;

  localparam int unsigned SUM_BITS = 31;

  mode_e                mode_r, mode_nxt;
  req_e                 pend_r, pend_nxt;
  pos_t                 target_r, target_nxt;
  pos_t                 final_r, final_nxt;
  logic [TICK_BITS-1:0] slow_start_r, slow_start_nxt;
  logic                 moving_r, moving_nxt;
  logic                 homing_r, homing_nxt;
  logic                 homed_r, homed_nxt;
  logic                 drv_cur_r, drv_cur_nxt;
  logic                 drv_spd_r, drv_spd_nxt;
  logic                 comp_done_r, comp_done_nxt;

  logic load_s, save_s, off_s, restart_s;
  pos_t load_val_s;
  pos_t cur;
  pos_t over_clamped;
  logic [POS_BITS:0] over_sum;

  logic [TICK_BITS-1:0] tick_delta;
  logic                 comp_neg;
  logic [31:0]          comp_mag;
  logic [63:0]          comp_recip;
  logic [SUM_BITS-1:0]  comp_quo;
  logic [SUM_BITS-1:0]  comp_ds;
  logic [SUM_BITS-1:0]  comp_sum;
  pos_t                 comp_pos;

  assign cur = item.current_position;
  assign tick_delta = item.now_ticks - slow_start_r;

  // Quotient by ten truncated toward zero, added to the reference and clamped.
  assign comp_neg   = comp_product[31];
  assign comp_mag   = comp_neg ? (32'd0 - comp_product) : comp_product;
  assign comp_recip = {32'd0, comp_mag} * {32'd0, RECIP_TEN};
  assign comp_quo   = SUM_BITS'(comp_recip[63:RECIP_SHIFT]);
  assign comp_ds    = comp_neg ? (SUM_BITS'(0) - comp_quo) : comp_quo;
  assign comp_sum   = SUM_BITS'(item.comp_start_position) + comp_ds;

  always_comb begin
    if (comp_sum[SUM_BITS-1]) begin
      comp_pos = '0;
    end else if (comp_sum > SUM_BITS'(cfg.max_position)) begin
      comp_pos = cfg.max_position;
    end else begin
      comp_pos = comp_sum[POS_BITS-1:0];
    end
  end

  assign over_sum = {1'b0, final_nxt} + (POS_BITS+1)'(cfg.backlash_steps);
  assign over_clamped = (over_sum > (POS_BITS+1)'(cfg.max_position)) ?
                        cfg.max_position : over_sum[POS_BITS-1:0];

  // Next state: the request is applied first, then the machine takes one step.
  always_comb begin
    mode_nxt       = mode_r;
    pend_nxt       = pend_r;
    target_nxt     = target_r;
    final_nxt      = final_r;
    slow_start_nxt = slow_start_r;
    moving_nxt     = moving_r;
    homing_nxt     = homing_r;
    homed_nxt      = homed_r;
    drv_cur_nxt    = drv_cur_r;
    drv_spd_nxt    = drv_spd_r;
    comp_done_nxt  = comp_done_r;
    load_s         = 1'b0;
    load_val_s     = '0;
    save_s         = 1'b0;
    off_s          = 1'b0;
    restart_s      = 1'b0;

    case (item.kind)
      KIND_HALT: begin
        pend_nxt = REQ_HALT;
        mode_nxt = MODE_IDLE;
      end
      KIND_ABS_MOVE: begin
        restart_s = 1'b1;
        final_nxt = item.new_target;
        pend_nxt  = REQ_ABS;
        mode_nxt  = MODE_IDLE;
      end
      KIND_HOME: begin
        if (!homing_r) begin
          restart_s = 1'b1;
          pend_nxt  = REQ_HOME;
          mode_nxt  = MODE_IDLE;
        end
      end
      KIND_REL_IN: begin
        restart_s = 1'b1;
        if (mode_r == MODE_OUT_SLOW || mode_r == MODE_OUT_FAST) begin
          mode_nxt = MODE_IDLE;
        end
        pend_nxt = REQ_IN;
      end
      KIND_REL_OUT: begin
        restart_s = 1'b1;
        if (mode_r == MODE_IN_SLOW || mode_r == MODE_IN_FAST) begin
          mode_nxt = MODE_IDLE;
        end
        pend_nxt = REQ_OUT;
      end
      KIND_REL_END: begin
        target_nxt  = cur;
        drv_cur_nxt = 1'b0;
        moving_nxt  = 1'b0;
        homing_nxt  = 1'b0;
        pend_nxt    = REQ_NONE;
        mode_nxt    = MODE_IDLE;
        save_s      = 1'b1;
      end
      KIND_ABORT_HOME: begin
        target_nxt  = cur;
        drv_cur_nxt = 1'b0;
        drv_spd_nxt = 1'b0;
        moving_nxt  = 1'b0;
        homing_nxt  = 1'b0;
        homed_nxt   = 1'b0;
        pend_nxt    = REQ_NONE;
        mode_nxt    = MODE_IDLE;
      end
      default: begin
      end
    endcase

    unique case (mode_nxt)
      MODE_IDLE: begin
        case (pend_nxt)
          REQ_HALT: begin
            target_nxt  = cur;
            drv_cur_nxt = 1'b0;
            homing_nxt  = 1'b0;
            moving_nxt  = 1'b0;
            off_s       = 1'b1;
            pend_nxt    = REQ_NONE;
          end
          REQ_IN, REQ_OUT: begin
            drv_cur_nxt    = 1'b1;
            drv_spd_nxt    = 1'b0;
            target_nxt     = (pend_nxt == REQ_OUT) ? cfg.max_position : '0;
            mode_nxt       = (pend_nxt == REQ_OUT) ? MODE_OUT_SLOW : MODE_IN_SLOW;
            pend_nxt       = REQ_NONE;
            slow_start_nxt = item.now_ticks;
          end
          REQ_HOME: begin
            mode_nxt = MODE_START_HOME;
          end
          REQ_ABS: begin
            drv_cur_nxt = 1'b1;
            drv_spd_nxt = 1'b1;
            if (!cfg.backlash_enable || cfg.backlash_steps == '0 ||
                final_nxt == cfg.max_position || final_nxt <= cur) begin
              target_nxt = final_nxt;
              mode_nxt   = MODE_POST_BLC;
            end else begin
              target_nxt = over_clamped;
              mode_nxt   = MODE_PRE_BLC;
            end
          end
          default: begin
          end
        endcase
      end
      MODE_START_HOME: begin
        homing_nxt  = 1'b1;
        homed_nxt   = 1'b0;
        moving_nxt  = 1'b1;
        pend_nxt    = REQ_NONE;
        drv_cur_nxt = 1'b1;
        drv_spd_nxt = 1'b1;
        load_s      = 1'b1;
        if (item.home_switch_pressed) begin
          load_val_s = '0;
          target_nxt = HOME_BEYOND_STEPS;
          mode_nxt   = MODE_OFF_SW;
        end else begin
          load_val_s = cfg.max_position;
          target_nxt = '0;
          mode_nxt   = MODE_TO_SW;
        end
      end
      MODE_OFF_SW: begin
        if (!item.home_switch_pressed) begin
          load_s     = 1'b1;
          load_val_s = '0;
          target_nxt = HOME_BEYOND_STEPS;
          mode_nxt   = MODE_BEYOND_SW;
        end else if (cur == target_nxt) begin
          load_s      = 1'b1;
          load_val_s  = target_nxt;
          drv_cur_nxt = 1'b0;
          drv_spd_nxt = 1'b0;
          moving_nxt  = 1'b0;
          homing_nxt  = 1'b0;
          homed_nxt   = 1'b0;
          mode_nxt    = MODE_IDLE;
        end
      end
      MODE_BEYOND_SW: begin
        if (cur == target_nxt) begin
          load_s     = 1'b1;
          load_val_s = HOME_RELOAD_VALUE;
          target_nxt = '0;
          mode_nxt   = MODE_TO_SW;
        end
      end
      MODE_TO_SW: begin
        if (item.home_switch_pressed) begin
          load_s     = 1'b1;
          load_val_s = '0;
          homed_nxt  = 1'b1;
          homing_nxt = 1'b0;
          restart_s  = 1'b1;
          pend_nxt   = REQ_ABS;
          mode_nxt   = MODE_IDLE;
          if (!cfg.comp_at_start_enable || !item.probe_attached) begin
            final_nxt = item.last_saved_position;
          end else if (!comp_done_r) begin
            moving_nxt = 1'b0;
            final_nxt  = comp_pos;
          end else begin
            moving_nxt = 1'b0;
            final_nxt  = item.last_saved_position;
          end
          comp_done_nxt = 1'b1;
        end else if (cur == '0) begin
          load_s      = 1'b1;
          load_val_s  = target_nxt;
          drv_cur_nxt = 1'b0;
          drv_spd_nxt = 1'b0;
          moving_nxt  = 1'b0;
          homing_nxt  = 1'b0;
          homed_nxt   = 1'b0;
          mode_nxt    = MODE_IDLE;
        end
      end
      MODE_PRE_BLC: begin
        if (cur == target_nxt) begin
          target_nxt = final_nxt;
          mode_nxt   = MODE_POST_BLC;
        end
      end
      MODE_IN_SLOW, MODE_OUT_SLOW: begin
        if (tick_delta > cfg.slow_phase_ticks) begin
          drv_spd_nxt = 1'b1;
          mode_nxt    = (mode_nxt == MODE_IN_SLOW) ? MODE_IN_FAST : MODE_OUT_FAST;
        end
      end
      MODE_POST_BLC, MODE_IN_FAST, MODE_OUT_FAST: begin
        if (cur == target_nxt) begin
          drv_cur_nxt = 1'b0;
          moving_nxt  = 1'b0;
          homing_nxt  = 1'b0;
          pend_nxt    = REQ_NONE;
          mode_nxt    = MODE_IDLE;
          save_s      = 1'b1;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase
  end

  always_comb begin
    res.target_position   = target_nxt;
    res.load_position     = load_s;
    res.load_value        = load_val_s;
    res.current_high      = drv_cur_nxt;
    res.speed_high        = drv_spd_nxt;
    res.moving_flag       = moving_nxt;
    res.homing_flag       = homing_nxt;
    res.homed_flag        = homed_nxt;
    res.save_position     = save_s;
    res.temp_comp_off     = off_s;
    res.temp_comp_restart = restart_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      pend_r       <= REQ_NONE;
      target_r     <= '0;
      final_r      <= '0;
      slow_start_r <= '0;
      moving_r     <= 1'b0;
      homing_r     <= 1'b0;
      homed_r      <= 1'b0;
      drv_cur_r    <= 1'b0;
      drv_spd_r    <= 1'b0;
      comp_done_r  <= 1'b0;
    end else if (step) begin
      mode_r       <= mode_nxt;
      pend_r       <= pend_nxt;
      target_r     <= target_nxt;
      final_r      <= final_nxt;
      slow_start_r <= slow_start_nxt;
      moving_r     <= moving_nxt;
      homing_r     <= homing_nxt;
      homed_r      <= homed_nxt;
      drv_cur_r    <= drv_cur_nxt;
      drv_spd_r    <= drv_spd_nxt;
      comp_done_r  <= comp_done_nxt;
    end
  end

  a_homing_moves: assert property (@(posedge clk) disable iff (!rst_n)
    homing_r |-> moving_r)
    else $error("Homing flag set without the moving flag.");

  a_home_modes_homing: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_OFF_SW || mode_r == MODE_BEYOND_SW || mode_r == MODE_TO_SW)
      |-> homing_r)
    else $error("Homing sequence running without the homing flag.");

  a_slow_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IN_SLOW || mode_r == MODE_OUT_SLOW) |-> (drv_cur_r && !drv_spd_r))
    else $error("Slow phase of a relative move without high current and low speed.");

  a_fast_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IN_FAST || mode_r == MODE_OUT_FAST) |-> (drv_cur_r && drv_spd_r))
    else $error("Fast phase of a relative move without high current and high speed.");

endmodule

/* src/focuser_motion_sequencer_top.sv */
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  fms_in_t, one poll or request
// out_     output     out_valid / out_stall fms_out_t, one result
// cfg_     input      cfg_we               cfg_index selects, cfg_wdata carries the value
//
// One result beat per input beat; a new input beat can be taken each cycle unless stalled.
// A beat passes an input register and then the result register.
// The temperature product is formed on acceptance; the divide, clamp and step follow.
// Reset is synchronous and active low; it restores config, flags and motion state, not data.
// A stalled result holds the pipeline, and in_stall rises once the input register is held.
module focuser_motion_sequencer_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  fms_pkg::fms_in_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output fms_pkg::fms_out_t                    out_data,
  input  logic                                 cfg_we,
  input  logic [fms_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [fms_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
  import fms_pkg::*;

  fms_cfg_t           cfg_r;
  logic               in_full_r;
  fms_in_t            in_data_r;
  logic signed [31:0] prod_r;
  logic               out_valid_r;
  fms_out_t           out_data_r;

  logic               advance;
  logic               step;
  logic               in_accept;
  logic signed [16:0] temp_delta;
  logic signed [32:0] prod_full;
  fms_out_t           res;

  assign advance   = !out_valid_r || !out_stall;
  assign step      = in_full_r && advance;
  assign in_stall  = in_full_r && !advance;
  assign in_accept = in_valid && !in_stall;

  assign temp_delta = 17'(in_data.current_temp) - 17'(in_data.comp_start_temp);
  assign prod_full  = 33'(temp_delta) * 33'(cfg_r.temp_coefficient);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_position         <= MAX_POSITION_RESET;
      cfg_r.backlash_enable      <= 1'b0;
      cfg_r.backlash_steps       <= '0;
      cfg_r.slow_phase_ticks     <= SLOW_TICKS_RESET;
      cfg_r.comp_at_start_enable <= 1'b0;
      cfg_r.temp_coefficient     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_POSITION:    cfg_r.max_position <= cfg_wdata[POS_BITS-1:0];
        CFG_BACKLASH_ENABLE: cfg_r.backlash_enable <= cfg_wdata[0];
        CFG_BACKLASH_STEPS:  cfg_r.backlash_steps <= cfg_wdata[15:0];
        CFG_SLOW_TICKS:      cfg_r.slow_phase_ticks <= cfg_wdata[TICK_BITS-1:0];
        CFG_COMP_ENABLE:     cfg_r.comp_at_start_enable <= cfg_wdata[0];
        CFG_TEMP_COEFF:      cfg_r.temp_coefficient <= cfg_wdata[TEMP_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_accept) begin
      in_full_r <= 1'b1;
    end else if (step) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_data_r <= in_data;
      prod_r    <= prod_full[31:0];
    end
  end

  fms_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .item         (in_data_r),
    .comp_product (prod_r),
    .cfg          (cfg_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
